FILE: hdl/kmc_pkg.sv
// Shared types and constants for the k-mer hash counter.
package kmc_pkg;

    typedef enum logic [1:0] {
        OP_BASE    = 2'd0,
        OP_RESTART = 2'd1,
        OP_READ    = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_COUNTED  = 3'd0,
        STS_FILLING  = 3'd1,
        STS_DROPPED  = 3'd2,
        STS_SLOTREAD = 3'd3,
        STS_CLEARED  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_FILL,
        RES_READ,
        RES_NEW,
        RES_HIT,
        RES_FULL
    } t_res_sel;

    typedef struct packed {
        logic     accept;
        logic     clr_step;
        logic     hash_init;
        logic     hash_step;
        logic     mem_rd;
        logic     probe_next;
        logic     wr_entry;
        logic     res_set;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic filling;
        logic hash_last;
        logic rd_valid;
        logic key_match;
        logic probe_last;
        logic clr_last;
        logic out_busy;
    } t_sts;

    localparam logic [63:0] HASH_START = 64'hcbf29ce484222325;
    localparam logic [63:0] HASH_LO    = 64'h00000000000001b3;

    function automatic logic [7:0] letter_code(input logic [1:0] code);
        logic [7:0] c;
        unique case (code)
            2'd0: c = 8'h41;
            2'd1: c = 8'h43;
            2'd2: c = 8'h47;
            default: c = 8'h54;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/kmc_ctrl.sv
// Sequencer for the k-mer hash counter: clear sweep, hashing, probing, result hand-off.
module kmc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_op,
    output kmc_pkg::t_cmd o_cmd,
    input  kmc_pkg::t_sts i_sts
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_EVAL, ST_HASH, ST_RD, ST_CHK, ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_clr_op, n_clr_op;
    logic   r_is_read, n_is_read;

    always_comb begin
        o_cmd     = '0;
        o_ready   = 1'b0;
        n_state   = r_state;
        n_clr_op  = r_clr_op;
        n_is_read = r_is_read;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_op ? ST_FIN : ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_is_read    = (i_op == kmc_pkg::OP_READ);
                    unique case (kmc_pkg::t_op'(i_op))
                        kmc_pkg::OP_BASE: n_state = ST_EVAL;
                        kmc_pkg::OP_READ: n_state = ST_RD;
                        kmc_pkg::OP_RESTART: begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_sel = kmc_pkg::RES_ZERO;
                            n_state       = ST_FIN;
                        end
                        kmc_pkg::OP_CLEAR: begin
                            o_cmd.res_set = 1'b1;
                            o_cmd.res_sel = kmc_pkg::RES_ZERO;
                            n_clr_op      = 1'b1;
                            n_state       = ST_CLEAR;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EVAL: begin
                if (i_sts.filling) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = kmc_pkg::RES_FILL;
                    n_state       = ST_FIN;
                end else begin
                    o_cmd.hash_init = 1'b1;
                    n_state         = ST_HASH;
                end
            end
            ST_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_last) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_CHK;
            end
            ST_CHK: begin
                priority if (r_is_read) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = kmc_pkg::RES_READ;
                    n_state       = ST_FIN;
                end else if (!i_sts.rd_valid) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.wr_entry = 1'b1;
                    o_cmd.res_sel  = kmc_pkg::RES_NEW;
                    n_state        = ST_FIN;
                end else if (i_sts.key_match) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.wr_entry = 1'b1;
                    o_cmd.res_sel  = kmc_pkg::RES_HIT;
                    n_state        = ST_FIN;
                end else if (i_sts.probe_last) begin
                    o_cmd.res_set = 1'b1;
                    o_cmd.res_sel = kmc_pkg::RES_FULL;
                    n_state       = ST_FIN;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = ST_RD;
                end
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_clr_op       = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_op  <= 1'b0;
            r_is_read <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_op  <= n_clr_op;
            r_is_read <= n_is_read;
        end
    end

`ifndef ASSERT_OFF
    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_entry && o_cmd.clr_step))
        else $error("entry write during clear sweep");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("result loaded over a pending beat");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second beat taken while item in work");
`endif

endmodule

FILE: hdl/kmc_dp.sv
// Datapath: base window, FNV-1a hash unit, slot table and result registers.
module kmc_dp #(
    parameter int TABLE_SLOTS = 4096,
    parameter int KMER_MAX    = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [5:0]    i_cfg_data,
    input  logic [1:0]    i_op,
    input  logic [1:0]    i_base,
    input  logic [11:0]   i_slot_index,
    input  kmc_pkg::t_cmd i_cmd,
    output kmc_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [63:0]   o_key,
    output logic [31:0]   o_count,
    output logic [11:0]   o_slot,
    output logic          o_occupied,
    output logic          o_first,
    output logic [2:0]    o_status
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    logic [5:0]            r_kmer_len;
    logic [63:0]           r_window;
    logic [5:0]            r_fill;
    logic [63:0]           r_key;
    logic [63:0]           r_hash;
    logic [63:0]           r_hkey;
    logic [5:0]            r_hcnt;
    logic [IDX_W-1:0]      r_slot;
    logic [IDX_W-1:0]      r_home;
    logic [IDX_W-1:0]      r_probe;
    logic [IDX_W-1:0]      r_clr_addr;
    logic                  r_rd_valid;
    logic [63:0]           r_rd_key;
    logic [COUNT_BITS-1:0] r_rd_cnt;

    logic                  mem_valid [TABLE_SLOTS];
    logic [63:0]           mem_key   [TABLE_SLOTS];
    logic [COUNT_BITS-1:0] mem_cnt   [TABLE_SLOTS];

    logic [63:0]           r_res_key;
    logic [31:0]           r_res_cnt;
    logic [11:0]           r_res_slot;
    logic                  r_res_occ;
    logic                  r_res_first;
    logic [2:0]            r_res_status;
    logic                  r_out_valid;

    logic [5:0]            w_k;
    logic [63:0]           w_mask;
    logic [63:0]           w_key;
    logic [6:0]            w_shamt;
    logic [63:0]           w_x;
    logic [63:0]           n_hash;
    logic [COUNT_BITS-1:0] w_sat;
    logic [11:0]           w_slot_out;
    logic [11:0]           w_home_out;

    always_comb begin
        priority if (r_kmer_len == 6'd0) begin
            w_k = 6'd1;
        end else if (r_kmer_len > 6'(KMER_MAX)) begin
            w_k = 6'(KMER_MAX);
        end else begin
            w_k = r_kmer_len;
        end
        w_mask  = (w_k >= 6'd32) ? '1 : ((64'd1 << {w_k, 1'b0}) - 64'd1);
        w_key   = r_window & w_mask;
        w_shamt = 7'd64 - {w_k, 1'b0};
        // xor the oldest letter, multiply by the FNV prime (2^40 + 0x1b3)
        w_x     = r_hash ^ {56'd0, kmc_pkg::letter_code(r_hkey[63:62])};
        n_hash  = (w_x << 40) + (w_x * kmc_pkg::HASH_LO);
        w_sat   = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + COUNT_BITS'(1);
        w_slot_out = 12'(32'(r_slot));
        w_home_out = 12'(32'(r_home));
    end

    assign o_sts.filling    = (r_fill < w_k);
    assign o_sts.hash_last  = (r_hcnt == 6'd1);
    assign o_sts.rd_valid   = r_rd_valid;
    assign o_sts.key_match  = (r_rd_key == r_key);
    assign o_sts.probe_last = (r_probe == '1);
    assign o_sts.clr_last   = (r_clr_addr == '1);
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len  <= 6'd8;
            r_window    <= '0;
            r_fill      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_kmer_len <= i_cfg_data;
            end
            if (i_cmd.accept && i_op == kmc_pkg::OP_BASE) begin
                r_window <= {r_window[61:0], i_base};
                if (r_fill < 6'(KMER_MAX)) begin
                    r_fill <= r_fill + 6'd1;
                end
            end else if (i_cmd.accept && i_op == kmc_pkg::OP_RESTART) begin
                r_window <= '0;
                r_fill   <= '0;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hash unit and probe pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_slot <= IDX_W'(32'(i_slot_index));
        end
        if (i_cmd.hash_init) begin
            r_key  <= w_key;
            r_hash <= kmc_pkg::HASH_START;
            r_hkey <= w_key << w_shamt;
            r_hcnt <= w_k;
        end
        if (i_cmd.hash_step) begin
            r_hash <= n_hash;
            r_hkey <= {r_hkey[61:0], 2'b00};
            r_hcnt <= r_hcnt - 6'd1;
            if (r_hcnt == 6'd1) begin
                r_slot  <= n_hash[IDX_W-1:0];
                r_home  <= n_hash[IDX_W-1:0];
                r_probe <= '0;
            end
        end
        if (i_cmd.probe_next) begin
            r_slot  <= r_slot + IDX_W'(1);
            r_probe <= r_probe + IDX_W'(1);
        end
    end

    // slot table
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem_valid[r_clr_addr] <= 1'b0;
        end else if (i_cmd.wr_entry) begin
            mem_valid[r_slot] <= 1'b1;
            mem_key[r_slot]   <= r_key;
            mem_cnt[r_slot]   <= (i_cmd.res_sel == kmc_pkg::RES_NEW) ?
                                 COUNT_BITS'(1) : w_sat;
        end
        if (i_cmd.mem_rd) begin
            r_rd_valid <= mem_valid[r_slot];
            r_rd_key   <= mem_key[r_slot];
            r_rd_cnt   <= mem_cnt[r_slot];
        end
    end

    // result staging and output beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            unique case (i_cmd.res_sel)
                kmc_pkg::RES_FILL: begin
                    r_res_key <= w_key;  r_res_cnt <= '0; r_res_slot <= '0;
                    r_res_occ <= 1'b0;   r_res_first <= 1'b0;
                    r_res_status <= kmc_pkg::STS_FILLING;
                end
                kmc_pkg::RES_READ: begin
                    r_res_key  <= r_rd_valid ? r_rd_key : '0;
                    r_res_cnt  <= r_rd_valid ? 32'(r_rd_cnt) : '0;
                    r_res_slot <= w_slot_out;
                    r_res_occ  <= r_rd_valid; r_res_first <= 1'b0;
                    r_res_status <= kmc_pkg::STS_SLOTREAD;
                end
                kmc_pkg::RES_NEW: begin
                    r_res_key <= r_key;  r_res_cnt <= 32'd1; r_res_slot <= w_slot_out;
                    r_res_occ <= 1'b1;   r_res_first <= 1'b1;
                    r_res_status <= kmc_pkg::STS_COUNTED;
                end
                kmc_pkg::RES_HIT: begin
                    r_res_key <= r_key;  r_res_cnt <= 32'(w_sat); r_res_slot <= w_slot_out;
                    r_res_occ <= 1'b1;   r_res_first <= 1'b0;
                    r_res_status <= kmc_pkg::STS_COUNTED;
                end
                kmc_pkg::RES_FULL: begin
                    r_res_key <= r_key;  r_res_cnt <= '0; r_res_slot <= w_home_out;
                    r_res_occ <= 1'b1;   r_res_first <= 1'b0;
                    r_res_status <= kmc_pkg::STS_DROPPED;
                end
                default: begin
                    r_res_key <= '0;     r_res_cnt <= '0; r_res_slot <= '0;
                    r_res_occ <= 1'b0;   r_res_first <= 1'b0;
                    r_res_status <= kmc_pkg::STS_CLEARED;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            o_key      <= r_res_key;
            o_count    <= r_res_cnt;
            o_slot     <= r_res_slot;
            o_occupied <= r_res_occ;
            o_first    <= r_res_first;
            o_status   <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending beat dropped");
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 6'(KMER_MAX))
        else $error("window fill beyond k-mer maximum");
`endif

endmodule

FILE: hdl/kmer_hash_counter.sv
// Top level of the k-mer hash counter: stream ports, controller and datapath.
// Base beat: the window shifts, the fill is checked and the hash seeded, then k FNV-1a
//   rounds, then a table read and a compare per probe, then the result is handed off.
// Restart, window-filling and slot-read beats skip the hashing rounds.
// Clear beat and reset both run a clearing pass over every slot of the table.
// One item is in work at a time; the result register frees input while a beat waits.
// Reset is synchronous active low; kmer_length returns to 8, window and table empty.
module kmer_hash_counter #(
    parameter int TABLE_SLOTS = 4096,
    parameter int KMER_MAX    = 32,
    parameter int COUNT_BITS  = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [5:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // base[1:0], slot_index[13:2], zero pad
    input  logic [1:0]   s_axis_tuser,   // operation[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,   // kmer_key[63:0], kmer_count[95:64],
                                         // slot_used[107:96], occupied[108],
                                         // first_seen[109], zero pad
    output logic [2:0]   m_axis_tuser    // status[2:0]
);

    kmc_pkg::t_cmd w_cmd;
    kmc_pkg::t_sts w_sts;
    logic [63:0]   w_key;
    logic [31:0]   w_count;
    logic [11:0]   w_slot;
    logic          w_occ;
    logic          w_first;

    assign o_cfg_ready = 1'b1;

    kmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    kmc_dp #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .KMER_MAX    (KMER_MAX),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_op         (s_axis_tuser),
        .i_base       (s_axis_tdata[1:0]),
        .i_slot_index (s_axis_tdata[13:2]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_key        (w_key),
        .o_count      (w_count),
        .o_slot       (w_slot),
        .o_occupied   (w_occ),
        .o_first      (w_first),
        .o_status     (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, w_first, w_occ, w_slot, w_count, w_key};

endmodule
